### src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge out of reset
`define MPS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// expression must never be true out of reset
`define MPS_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

### src/mps_pkg.sv
// ----------------------------------------------------------------------------
// mps_pkg
// Shared widths, register indexes and the cell control word.
// ----------------------------------------------------------------------------
package mps_pkg;

    localparam int DATA_W          = 32;
    localparam int DIM_W           = 4;
    localparam int EXP_W           = 31;
    localparam int CFG_IDX_W       = 1;
    localparam int DEFAULT_MAX_DIM = 8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DIMENSION = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPONENT  = 1'd1;

    // control word broadcast to every cell
    typedef struct packed {
        logic ident;      // power row := identity row
        logic copy;       // rotating row := base row, restart A index
        logic rotate;     // take neighbor's rotating row
        logic mac;        // issue one multiply-accumulate
        logic mac_first;  // first term of the sum: overwrite accumulator
        logic use_pow;    // left operand is power row (else base row)
        logic wb_pow;     // power row := accumulator
        logic wb_base;    // base row := accumulator
    } cell_ctl_t;

endpackage

### src/mps_cell.sv
// ----------------------------------------------------------------------------
// mps_cell
// One row cell: holds one row of base, power, rotating and accumulator
// matrices, and multiplies-accumulates one element per cycle.
// ----------------------------------------------------------------------------
module mps_cell #(
    parameter int MAX_DIM = mps_pkg::DEFAULT_MAX_DIM,
    parameter int IDX     = 0,
    parameter int IW      = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1,
    parameter int NW      = $clog2(MAX_DIM + 1)
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  mps_pkg::cell_ctl_t                      ctl,
    input  logic [NW-1:0]                           n,
    input  logic                                    ld_we,
    input  logic [IW-1:0]                           ld_col,
    input  logic [mps_pkg::DATA_W-1:0]              ld_data,
    input  logic [IW-1:0]                           mac_col,
    input  logic [MAX_DIM-1:0][mps_pkg::DATA_W-1:0] rot_in,
    output logic [MAX_DIM-1:0][mps_pkg::DATA_W-1:0] rot_out,
    output logic [MAX_DIM-1:0][mps_pkg::DATA_W-1:0] pow_out
);
    import mps_pkg::*;

    logic [MAX_DIM-1:0][DATA_W-1:0] base_reg;
    logic [MAX_DIM-1:0][DATA_W-1:0] pow_reg;
    logic [MAX_DIM-1:0][DATA_W-1:0] rot_reg;
    logic [MAX_DIM-1:0][DATA_W-1:0] acc_reg;
    logic [IW-1:0]                  aidx_reg;
    logic [IW-1:0]                  aidx_next;
    logic [DATA_W-1:0]              prod_reg;
    logic [IW-1:0]                  col_d_reg;
    logic                           first_d_reg;
    logic                           valid_d_reg;
    logic [DATA_W-1:0]              a_val;
    logic [DATA_W-1:0]              b_val;

    assign rot_out = rot_reg;
    assign pow_out = pow_reg;

    // operand select
    assign a_val = ctl.use_pow ? pow_reg[aidx_reg] : base_reg[aidx_reg];
    assign b_val = rot_reg[mac_col];

    // A column index walks with the rotation, wrapping at n
    assign aidx_next = ((NW'(aidx_reg) + NW'(1)) == n) ? '0 : aidx_reg + IW'(1);

    // row storage
    always_ff @(posedge clk)
    begin
        for (int c = 0; c < MAX_DIM; c++)
        begin
            if (ctl.ident)
                pow_reg[c] <= (c == IDX) ? DATA_W'(1) : '0;
        end
        if (ctl.wb_pow)
            pow_reg <= acc_reg;
        if (ld_we)
            base_reg[ld_col] <= ld_data;
        if (ctl.wb_base)
            base_reg <= acc_reg;
        if (ctl.copy)
            rot_reg <= base_reg;
        else if (ctl.rotate)
            rot_reg <= rot_in;
        if (ctl.copy)
            aidx_reg <= IW'(IDX);
        else if (ctl.rotate)
            aidx_reg <= aidx_next;
    end

    // multiply stage and accumulate stage
    always_ff @(posedge clk)
    begin
        prod_reg    <= a_val * b_val;
        col_d_reg   <= mac_col;
        first_d_reg <= ctl.mac_first;
        if (valid_d_reg)
            acc_reg[col_d_reg] <= first_d_reg ? prod_reg : acc_reg[col_d_reg] + prod_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_d_reg <= 1'b0;
        else
            valid_d_reg <= ctl.mac;
    end

endmodule

### src/matrix_power_by_squaring.sv
// ----------------------------------------------------------------------------
// matrix_power_by_squaring
// Loads an n x n matrix, raises it to a power by repeated squaring on a
// ring of row cells, and streams the result out row-major.
// ----------------------------------------------------------------------------
//  channel   | handshake             | payload
//  ----------+-----------------------+--------------------------------
//  input     | in_valid / in_ready   | element_value
//  output    | out_valid / out_ready | result_value, result_last
//  config    | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// Loading takes one word per cycle; one matrix product runs on the cell ring
// (one MAC per cell per cycle, n columns times n rotations).
// A power costs (popcount(e) + bits(e) - 1) products, then the n*n result words stream out.
// Reset clears control only; matrix rows are undefined until loaded.
// Input is held off during compute and output; output stalls freeze the block.
module matrix_power_by_squaring #(
    parameter int MAX_DIM = mps_pkg::DEFAULT_MAX_DIM
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [mps_pkg::DATA_W-1:0]   element_value,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [mps_pkg::DATA_W-1:0]   result_value,
    output logic                                result_last,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mps_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mps_pkg::DATA_W-1:0]          cfg_data
);
    import mps_pkg::*;

`include "assert_macros.svh"

    localparam int IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int NW = $clog2(MAX_DIM + 1);

    localparam logic [2:0] S_LOAD  = 3'd0;
    localparam logic [2:0] S_IDENT = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_COPY  = 3'd3;
    localparam logic [2:0] S_MAC   = 3'd4;
    localparam logic [2:0] S_DRAIN = 3'd5;
    localparam logic [2:0] S_WB    = 3'd6;
    localparam logic [2:0] S_OUT   = 3'd7;

    logic [2:0]       state_reg, state_next;
    logic [DIM_W-1:0] dim_reg;
    logic [EXP_W-1:0] exp_reg;
    logic [EXP_W-1:0] rem_reg, rem_next;
    logic             mul_done_reg, mul_done_next;
    logic             use_pow_reg, use_pow_next;
    logic [IW-1:0]    row_reg, row_next;
    logic [IW-1:0]    col_reg, col_next;
    logic [IW-1:0]    t_reg, t_next;
    logic [NW-1:0]    n_eff;
    logic             row_end, col_end, t_end;
    logic             in_acc, out_acc, cfg_acc;
    cell_ctl_t        ctl;

    logic [MAX_DIM-1:0][MAX_DIM-1:0][DATA_W-1:0] rot_rows;
    logic [MAX_DIM-1:0][MAX_DIM-1:0][DATA_W-1:0] rot_ins;
    logic [MAX_DIM-1:0][MAX_DIM-1:0][DATA_W-1:0] pow_rows;

    // effective size: zero reads as one, saturate at MAX_DIM
    always_comb
    begin
        if (dim_reg == '0)
            n_eff = NW'(1);
        else if (32'(dim_reg) > MAX_DIM)
            n_eff = NW'(MAX_DIM);
        else
            n_eff = NW'(dim_reg);
    end

    assign col_end = (NW'(col_reg) == n_eff - NW'(1));
    assign row_end = (NW'(row_reg) == n_eff - NW'(1));
    assign t_end   = (NW'(t_reg) == n_eff - NW'(1));

    assign in_ready  = (state_reg == S_LOAD);
    assign out_valid = (state_reg == S_OUT);
    assign cfg_ready = 1'b1;
    assign in_acc    = in_valid && in_ready;
    assign out_acc   = out_valid && out_ready;
    assign cfg_acc   = cfg_valid && cfg_ready;

    assign result_value = pow_rows[row_reg][col_reg];
    assign result_last  = row_end && col_end;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_reg <= DIM_W'(1);
            exp_reg <= EXP_W'(1);
        end
        else if (cfg_acc)
        begin
            unique case (cfg_index)
                CFG_DIMENSION: dim_reg <= cfg_data[DIM_W-1:0];
                CFG_EXPONENT:  exp_reg <= cfg_data[EXP_W-1:0];
                default:       ;
            endcase
        end
    end

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        rem_next      = rem_reg;
        mul_done_next = mul_done_reg;
        use_pow_next  = use_pow_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        t_next        = t_reg;
        ctl           = '0;
        ctl.use_pow   = use_pow_reg;
        unique case (state_reg)
            S_LOAD:
            begin
                if (in_acc)
                begin
                    col_next = col_end ? '0 : col_reg + IW'(1);
                    if (col_end)
                        row_next = row_end ? '0 : row_reg + IW'(1);
                    if (col_end && row_end)
                        state_next = S_IDENT;
                end
                if (cfg_acc && cfg_index == CFG_DIMENSION)
                begin
                    row_next = '0;
                    col_next = '0;
                end
            end
            S_IDENT:
            begin
                ctl.ident     = 1'b1;
                rem_next      = exp_reg;
                mul_done_next = 1'b0;
                state_next    = S_CHECK;
            end
            S_CHECK:
            begin
                priority if (rem_reg == '0)
                    state_next = S_OUT;
                else if (rem_reg[0] && !mul_done_reg)
                begin
                    use_pow_next = 1'b1;
                    state_next   = S_COPY;
                end
                else
                begin
                    rem_next      = rem_reg >> 1;
                    mul_done_next = 1'b0;
                    use_pow_next  = 1'b0;
                    state_next    = ((rem_reg >> 1) != '0) ? S_COPY : S_OUT;
                end
            end
            S_COPY:
            begin
                ctl.copy   = 1'b1;
                t_next     = '0;
                col_next   = '0;
                state_next = S_MAC;
            end
            S_MAC:
            begin
                ctl.mac       = 1'b1;
                ctl.mac_first = (t_reg == '0);
                if (col_end)
                begin
                    ctl.rotate = 1'b1;
                    col_next   = '0;
                    t_next     = t_reg + IW'(1);
                    if (t_end)
                        state_next = S_DRAIN;
                end
                else
                    col_next = col_reg + IW'(1);
            end
            S_DRAIN:
                state_next = S_WB;
            S_WB:
            begin
                ctl.wb_pow  = use_pow_reg;
                ctl.wb_base = !use_pow_reg;
                if (use_pow_reg)
                    mul_done_next = 1'b1;
                row_next   = '0;
                col_next   = '0;
                state_next = S_CHECK;
            end
            S_OUT:
            begin
                if (out_acc)
                begin
                    col_next = col_end ? '0 : col_reg + IW'(1);
                    if (col_end)
                        row_next = row_end ? '0 : row_reg + IW'(1);
                    if (col_end && row_end)
                        state_next = S_LOAD;
                end
            end
            default:
                state_next = S_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_LOAD;
            rem_reg      <= '0;
            mul_done_reg <= 1'b0;
            use_pow_reg  <= 1'b0;
            row_reg      <= '0;
            col_reg      <= '0;
            t_reg        <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            rem_reg      <= rem_next;
            mul_done_reg <= mul_done_next;
            use_pow_reg  <= use_pow_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
            t_reg        <= t_next;
        end
    end

    // ring of row cells; the ring closes at row n-1
    for (genvar i = 0; i < MAX_DIM; i++)
    begin : g_cell
        if (i == MAX_DIM - 1)
        begin : g_wrap
            assign rot_ins[i] = rot_rows[0];
        end
        else
        begin : g_link
            assign rot_ins[i] = (NW'(i + 1) < n_eff) ? rot_rows[i + 1] : rot_rows[0];
        end

        mps_cell #(
            .MAX_DIM (MAX_DIM),
            .IDX     (i),
            .IW      (IW),
            .NW      (NW)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl     (ctl),
            .n       (n_eff),
            .ld_we   (in_acc && (row_reg == IW'(i))),
            .ld_col  (col_reg),
            .ld_data (element_value),
            .mac_col (col_reg),
            .rot_in  (rot_ins[i]),
            .rot_out (rot_rows[i]),
            .pow_out (pow_rows[i])
        );
    end

    // checks
    `MPS_NEVER(a_in_out_excl, in_ready && out_valid, "input and output open together")
    `MPS_ASSERT(a_last_to_load, out_acc && result_last |=> in_ready, "no return to load")
    `MPS_ASSERT(a_load_to_ident, in_acc && row_end && col_end |=> state_reg == S_IDENT, "no compute start")
    `MPS_NEVER(a_mac_in_load, ctl.mac && in_ready, "MAC issued while loading")

endmodule
